// File: hdl/postfix_expression_evaluator_core_defines.svh
// Assertion macros shared by the evaluator's checker.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, quiet while i_rst_n is low.
`define PFX_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, quiet while i_rst_n is low.
`define PFX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pfx_pkg.sv
// Shared constants, types and command/status structs of the postfix evaluator.
`default_nettype none
package pfx_pkg;

    localparam int DATA_W          = 32;
    localparam int STATUS_W        = 3;
    localparam int STACK_DEPTH_DEF = 16;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] TEN      = 8'd10;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZ  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DEPTH = 3'd4;

    typedef enum logic [1:0] {
        RD_ZERO   = 2'd0,
        RD_TOP    = 2'd1,
        RD_SECOND = 2'd2
    } t_rd_sel;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_OTHER = 3'd4
    } t_op;

    typedef struct packed {
        logic    latch;
        logic    acc_digit;
        logic    flush;
        logic    op_check;
        logic    take_y;
        logic    take_x;
        logic    exec;
        logic    div_take;
        logic    push_res;
        logic    emit;
        t_rd_sel rd_sel;
    } t_cmd;

    typedef struct packed {
        logic err_pending;
        logic is_digit;
        logic is_space;
        logic is_final;
        logic count_lt2;
        t_op  op;
        logic y_zero;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// File: hdl/pfx_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pfx_ram #(
    parameter int WIDTH = pfx_pkg::DATA_W,
    parameter int DEPTH = pfx_pkg::STACK_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// File: hdl/pfx_div.sv
// Iterative signed divider, truncating toward zero, one quotient bit per cycle.
`default_nettype none
module pfx_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pfx_pkg::DATA_W-1:0] i_dividend,
    input  logic [pfx_pkg::DATA_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [pfx_pkg::DATA_W-1:0] o_quotient
);

    localparam int DW    = pfx_pkg::DATA_W;
    localparam int CNT_W = $clog2(DW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_quo;
    logic [DW-1:0]    r_dvs;
    logic             r_neg;

    logic [DW:0]      w_shift;
    logic [DW:0]      w_trial;
    logic [DW-1:0]    w_mag_a;
    logic [DW-1:0]    w_mag_b;

    assign w_mag_a = i_dividend[DW-1] ? (DW'(0) - i_dividend) : i_dividend;
    assign w_mag_b = i_divisor[DW-1]  ? (DW'(0) - i_divisor)  : i_divisor;
    assign w_shift = {r_rem, r_quo[DW-1]};
    assign w_trial = w_shift - {1'b0, r_dvs};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(DW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Restoring shift-subtract on magnitudes
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_quo <= w_mag_a;
            r_dvs <= w_mag_b;
            r_neg <= i_dividend[DW-1] ^ i_divisor[DW-1];
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (!w_trial[DW]) begin
                r_rem <= w_trial[DW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (DW'(0) - r_quo) : r_quo;

endmodule
`default_nettype wire

// File: hdl/pfx_datapath.sv
// Datapath: number accumulator, operand stack, ALU, divider and result register.
`default_nettype none
module pfx_datapath #(
    parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [7:0]                          i_char_code,
    input  logic                                i_is_final,
    input  pfx_pkg::t_cmd                       i_cmd,
    output pfx_pkg::t_sts                       o_sts,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic signed [pfx_pkg::DATA_W-1:0]   o_value,
    output logic [pfx_pkg::STATUS_W-1:0]        o_status
);

    localparam int DW = pfx_pkg::DATA_W;
    localparam int SW = pfx_pkg::STATUS_W;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Payload registers
    logic [7:0]    r_char;
    logic          r_final;
    logic [DW-1:0] r_x;
    logic [DW-1:0] r_y;
    logic [DW-1:0] r_result;
    logic [DW-1:0] r_value;
    logic [SW-1:0] r_status;

    // Control registers
    logic [DW-1:0] r_acc;
    logic [DW-1:0] n_acc;
    logic          r_in_num;
    logic          n_in_num;
    logic [SW-1:0] r_err;
    logic [SW-1:0] n_err;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    logic          n_out_valid;

    logic          w_full;
    logic          w_flush_act;
    logic          w_wr_en;
    logic [DW-1:0] w_wr_data;
    logic [AW-1:0] w_rd_addr;
    logic [DW-1:0] w_rd_data;
    logic [CW-1:0] w_cnt_m1;
    logic [CW-1:0] w_cnt_m2;
    logic [3:0]    w_digit;
    pfx_pkg::t_op  w_op;
    logic          w_y_zero;
    logic          w_div_start;
    logic          w_div_done;
    logic [DW-1:0] w_div_q;
    logic [SW-1:0] w_fin_status;

    assign w_full      = (r_count == CW'(STACK_DEPTH));
    assign w_flush_act = i_cmd.flush && r_in_num && (r_err == pfx_pkg::ST_OK);
    assign w_wr_en     = (w_flush_act || i_cmd.push_res) && !w_full;
    assign w_wr_data   = i_cmd.push_res ? r_result : r_acc;
    assign w_cnt_m1    = r_count - CW'(1);
    assign w_cnt_m2    = r_count - CW'(2);
    assign w_digit     = 4'(r_char - pfx_pkg::CH_ZERO);
    assign w_y_zero    = (r_y == '0);
    assign w_div_start = i_cmd.exec && (w_op == pfx_pkg::OP_DIV) && !w_y_zero;

    always_comb begin
        unique case (i_cmd.rd_sel)
            pfx_pkg::RD_TOP:    w_rd_addr = w_cnt_m1[AW-1:0];
            pfx_pkg::RD_SECOND: w_rd_addr = w_cnt_m2[AW-1:0];
            default:            w_rd_addr = '0;
        endcase
    end

    always_comb begin
        unique case (r_char)
            pfx_pkg::CH_PLUS:  w_op = pfx_pkg::OP_ADD;
            pfx_pkg::CH_MINUS: w_op = pfx_pkg::OP_SUB;
            pfx_pkg::CH_STAR:  w_op = pfx_pkg::OP_MUL;
            pfx_pkg::CH_SLASH: w_op = pfx_pkg::OP_DIV;
            default:           w_op = pfx_pkg::OP_OTHER;
        endcase
    end

    always_comb begin
        if (r_err != pfx_pkg::ST_OK) begin
            w_fin_status = r_err;
        end else if (r_count != CW'(1)) begin
            w_fin_status = pfx_pkg::ST_DEPTH;
        end else begin
            w_fin_status = pfx_pkg::ST_OK;
        end
    end

    pfx_ram #(
        .WIDTH (DW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    pfx_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_x),
        .i_divisor  (r_y),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    // Next-state of accumulator, error, stack count and output valid
    always_comb begin
        n_acc       = r_acc;
        n_in_num    = r_in_num;
        n_err       = r_err;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.acc_digit) begin
            n_acc    = (r_acc << 3) + (r_acc << 1) + {{(DW-4){1'b0}}, w_digit};
            n_in_num = 1'b1;
        end
        if (w_flush_act) begin
            n_in_num = 1'b0;
            n_acc    = '0;
            if (w_full) begin
                n_err = pfx_pkg::ST_OVER;
            end else begin
                n_count = r_count + CW'(1);
            end
        end
        if (i_cmd.op_check && (r_count < CW'(2))) begin
            n_count = '0;
            if (r_err == pfx_pkg::ST_OK) begin
                n_err = pfx_pkg::ST_UNDER;
            end
        end
        if (i_cmd.take_x) begin
            n_count = w_cnt_m2;
        end
        if (i_cmd.exec && (w_op == pfx_pkg::OP_DIV) && w_y_zero
                && (r_err == pfx_pkg::ST_OK)) begin
            n_err = pfx_pkg::ST_DIVZ;
        end
        if (i_cmd.push_res) begin
            if (w_full) begin
                if (r_err == pfx_pkg::ST_OK) begin
                    n_err = pfx_pkg::ST_OVER;
                end
            end else begin
                n_count = r_count + CW'(1);
            end
        end
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_count     = '0;
            n_acc       = '0;
            n_in_num    = 1'b0;
            n_err       = pfx_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_in_num    <= 1'b0;
            r_err       <= pfx_pkg::ST_OK;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_in_num    <= n_in_num;
            r_err       <= n_err;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_char  <= i_char_code;
            r_final <= i_is_final;
        end
        if (i_cmd.take_y) begin
            r_y <= w_rd_data;
        end
        if (i_cmd.take_x) begin
            r_x <= w_rd_data;
        end
        if (i_cmd.exec) begin
            unique case (w_op)
                pfx_pkg::OP_ADD: r_result <= r_x + r_y;
                pfx_pkg::OP_SUB: r_result <= r_x - r_y;
                pfx_pkg::OP_MUL: r_result <= DW'(r_x * r_y);
                default:         r_result <= r_result;
            endcase
        end
        if (i_cmd.div_take) begin
            r_result <= w_div_q;
        end
        if (i_cmd.emit) begin
            r_value  <= (w_fin_status == pfx_pkg::ST_OK) ? w_rd_data : '0;
            r_status <= w_fin_status;
        end
    end

    assign o_sts.err_pending = (r_err != pfx_pkg::ST_OK);
    assign o_sts.is_digit    = (r_char >= pfx_pkg::CH_ZERO) && (r_char <= pfx_pkg::CH_NINE);
    assign o_sts.is_space    = (r_char == pfx_pkg::CH_SPACE) || (r_char == pfx_pkg::CH_TAB);
    assign o_sts.is_final    = r_final;
    assign o_sts.count_lt2   = (r_count < CW'(2));
    assign o_sts.op          = w_op;
    assign o_sts.y_zero      = w_y_zero;
    assign o_sts.div_done    = w_div_done;
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_status    = r_status;

endmodule
`default_nettype wire

// File: hdl/pfx_ctrl.sv
// Controller: sequences one character through flush, pop, execute, push and report.
`default_nettype none
module pfx_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  pfx_pkg::t_sts i_sts,
    output pfx_pkg::t_cmd o_cmd,
    output logic          o_stall
);

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_CHAR      = 13'b0000000000010,
        S_FLUSH     = 13'b0000000000100,
        S_OP        = 13'b0000000001000,
        S_RDY       = 13'b0000000010000,
        S_RDX       = 13'b0000000100000,
        S_EXEC      = 13'b0000001000000,
        S_DIV       = 13'b0000010000000,
        S_PUSH      = 13'b0000100000000,
        S_FIN_CHK   = 13'b0001000000000,
        S_FIN_FLUSH = 13'b0010000000000,
        S_FIN_READ  = 13'b0100000000000,
        S_EMIT      = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.rd_sel = pfx_pkg::RD_ZERO;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_CHAR;
                end
            end
            S_CHAR: begin
                if (i_sts.err_pending) begin
                    n_state = S_FIN_CHK;
                end else if (i_sts.is_digit) begin
                    o_cmd.acc_digit = 1'b1;
                    n_state         = S_FIN_CHK;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_OP;
            end
            S_OP: begin
                if (i_sts.err_pending || i_sts.is_space) begin
                    n_state = S_FIN_CHK;
                end else begin
                    o_cmd.op_check = 1'b1;
                    if (i_sts.count_lt2) begin
                        n_state = S_FIN_CHK;
                    end else begin
                        o_cmd.rd_sel = pfx_pkg::RD_TOP;
                        n_state      = S_RDY;
                    end
                end
            end
            S_RDY: begin
                o_cmd.take_y = 1'b1;
                o_cmd.rd_sel = pfx_pkg::RD_SECOND;
                n_state      = S_RDX;
            end
            S_RDX: begin
                o_cmd.take_x = 1'b1;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                unique case (i_sts.op)
                    pfx_pkg::OP_DIV:
                        n_state = i_sts.y_zero ? S_FIN_CHK : S_DIV;
                    pfx_pkg::OP_ADD, pfx_pkg::OP_SUB, pfx_pkg::OP_MUL:
                        n_state = S_PUSH;
                    default:
                        n_state = S_FIN_CHK;
                endcase
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.push_res = 1'b1;
                n_state        = S_FIN_CHK;
            end
            S_FIN_CHK: begin
                n_state = i_sts.is_final ? S_FIN_FLUSH : S_IDLE;
            end
            S_FIN_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_FIN_READ;
            end
            S_FIN_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

// File: hdl/postfix_expression_evaluator_core.sv
// Top level of the postfix (reverse Polish) expression evaluator.
// Feed the expression one ASCII character per item, with i_is_final set on the
// last one. Digit runs build an unsigned 32-bit number (10*v + digit, wrapping)
// that is pushed on the operand stack when a non-digit arrives or the expression
// ends; space and tab only end a number. Any other character pops two operands
// and '+', '-', '*', '/' push the wrapped result (division truncates toward
// zero); other characters push nothing. The first error (underflow, overflow,
// divide by zero) sticks until the final character, which produces exactly one
// result item carrying the value and a status, then clears all state. Items are
// processed one at a time: the controller steps each character through its state
// sequence, and '/' also waits on the 32-step divider. A final character then
// passes through the final flush, read and emit states, and the emit waits while
// the previous result still sits stalled in the output register. The result sits
// in an output register, so the next expression can start while an earlier result
// still waits; only a second final character stalls until that register is
// taken. The stack is a small RAM that needs no clearing: no entry above the
// stack count is ever read.
`default_nettype none
module postfix_expression_evaluator_core #(
    parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Character channel
    input  logic                                i_valid,
    input  logic [7:0]                          i_char_code,
    input  logic                                i_is_final,
    output logic                                o_stall,
    // Result channel
    output logic                                o_valid,
    output logic signed [pfx_pkg::DATA_W-1:0]   o_value,
    output logic [pfx_pkg::STATUS_W-1:0]        o_status,
    input  logic                                i_stall
);

    pfx_pkg::t_cmd w_cmd;
    pfx_pkg::t_sts w_sts;

    // Controller: one-hot sequencer, stalls the character channel while busy
    pfx_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_stall (o_stall)
    );

    // Datapath: stack RAM, accumulator, ALU, divider and the result register
    pfx_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_code (i_char_code),
        .i_is_final  (i_is_final),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_value     (o_value),
        .o_status    (o_status)
    );

endmodule
`default_nettype wire

// File: hdl/pfx_checker.sv
// Port-level checker for the postfix evaluator, bound to the top level.
`default_nettype none
`include "postfix_expression_evaluator_core_defines.svh"
module pfx_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic signed [pfx_pkg::DATA_W-1:0]   o_value,
    input logic [pfx_pkg::STATUS_W-1:0]        o_status,
    input logic                                i_stall
);

    // An accepted character moves the controller out of idle, so an accept is followed by a stall
    `PFX_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall, "no stall after accept")

    // Status never goes beyond the final-depth code
    `PFX_ASSERT_NOW(a_status_range, o_valid, o_status <= pfx_pkg::ST_DEPTH, "status out of range")

    // An error result carries a zero value
    `PFX_ASSERT_NOW(a_err_value_zero, o_valid && (o_status != pfx_pkg::ST_OK), o_value == '0, "error result with nonzero value")

    // A stalled result holds
    `PFX_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_value) && $stable(o_status), "stalled result changed")

endmodule

bind postfix_expression_evaluator_core pfx_checker u_pfx_checker (.*);
`default_nettype wire
